>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the ternary search core.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define TSST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define TSST_NEVER(label, clk, rst, cond, msg) \
   `TSST_ASSERT(label, clk, rst, !(cond), msg)

`endif

>>> hw/rtl/tsst_pkg.sv
// Types and constants of the ternary search core.
// Used by the comparator and the top level; depends on nothing.
package tsst_pkg;

   // Request kinds carried in the req_type field.
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SEARCH = 1'b1;

   // Reciprocal of three for spans below 1024: floor(x * 683 / 2048) == x / 3.
   localparam logic [9:0] RECIP_THIRD = 10'd683;
   localparam int         THIRD_SHIFT = 11;

   // One input item.
   typedef struct packed {
      logic               req_type;
      logic [9:0]         entry_index;
      logic signed [31:0] entry_value;
      logic signed [31:0] target;
      logic [9:0]         range_left;
      logic [9:0]         range_right;
   } req_item_type;

   // One result item.
   typedef struct packed {
      logic       found;
      logic [9:0] position;
   } rsp_item_type;

   // Outcome of comparing the search key with one table word.
   typedef struct packed {
      logic eq;
      logic lt;
      logic gt;
   } cmp_flags_type;

endpackage

>>> hw/rtl/ternary_search_sorted_table_core.sv
// Top level of the ternary search core: sequencer, table memory and comparator.
// Depends on tsst_pkg, tsst_ram, tsst_cmp and assert_macros.svh.
//
// Usage. An item is accepted at a rising edge where start is high and busy is
// low; req_item.req_type selects a table write or a search. A write stores
// entry_value at entry_index (indices at or beyond TABLE_DEPTH are dropped),
// gives no result and leaves busy low. A search raises busy and runs rounds
// of span computation (a multiply by the reciprocal of three), two reads of
// the single memory read port, then a decision. A round that matches ends
// the search; a range found empty at span computation ends it there. The
// result is on rsp_item for exactly one cycle with rsp_valid high, in the
// same cycle busy drops, so a new item may be accepted then. A full
// 1024-entry range needs at most seven rounds. range_right saturates to the
// last table entry. Reset returns the sequencer to idle and clears busy and
// rsp_valid; the table keeps no defined contents and must be written before
// it is searched. The receiver cannot stall, so rsp_valid is a one-cycle
// strobe that must be taken when shown.
`include "assert_macros.svh"

module ternary_search_sorted_table_core
   import tsst_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam int AW = $clog2(TABLE_DEPTH);
   // Highest index a search may probe.
   localparam logic [9:0] SAT_LAST =
      (TABLE_DEPTH > 1024) ? 10'd1023 : 10'(TABLE_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPAN,
      S_PROBE1,
      S_PROBE2,
      S_DECIDE
   } state_type;

   state_type          state_ff, state_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   logic signed [31:0] key_ff, key_in;
   logic [11:0]        lo_ff, lo_in;
   logic [11:0]        hi_ff, hi_in;
   logic [8:0]         span_ff, span_in;
   logic [9:0]         p1_ff, p1_in;
   logic [9:0]         p2_ff, p2_in;
   logic               eq1_ff, eq1_in;
   logic               lt1_ff, lt1_in;

   logic [11:0]        diff;
   logic [19:0]        span_prod;
   logic               mem_we;
   logic [AW-1:0]      rd_addr;
   logic [31:0]        rd_word;
   cmp_flags_type      flags;

   // Table memory, one read port shared by both probes of a round.
   tsst_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (AW'(req_item.entry_index)),
      .wr_data (req_item.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // One comparator judges each word as it leaves the memory.
   tsst_cmp u_cmp (
      .key   (key_ff),
      .word  ($signed(rd_word)),
      .flags (flags)
   );

   // Distance between the range ends divided by three through the reciprocal.
   assign diff      = hi_ff - lo_ff;
   assign span_prod = 20'(diff[9:0]) * 20'(RECIP_THIRD);

   // Sequencer next-state and datapath logic.
   always_comb begin
      state_in     = state_ff;
      busy_in      = busy_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      span_in      = span_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      eq1_in       = eq1_ff;
      lt1_in       = lt1_ff;
      mem_we       = 1'b0;
      rd_addr      = AW'(p2_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start && !busy_ff) begin
               if (req_item.req_type == REQ_SEARCH) begin
                  key_in   = req_item.target;
                  lo_in    = {2'b00, req_item.range_left};
                  hi_in    = {2'b00, (req_item.range_right > SAT_LAST) ?
                                     SAT_LAST : req_item.range_right};
                  busy_in  = 1'b1;
                  state_in = S_SPAN;
               end else begin
                  mem_we = ({22'd0, req_item.entry_index} < 32'(TABLE_DEPTH));
               end
            end
         end
         S_SPAN: begin
            if ($signed(hi_ff) < $signed(lo_ff)) begin
               // Range is empty: report not found.
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{found: 1'b0, position: 10'd0};
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else begin
               span_in  = span_prod[THIRD_SHIFT +: 9];
               state_in = S_PROBE1;
            end
         end
         S_PROBE1: begin
            // Probe points at one and two thirds; the first is read now.
            p1_in    = 10'(lo_ff + {3'b000, span_ff});
            p2_in    = 10'(hi_ff - {3'b000, span_ff});
            rd_addr  = AW'(p1_in);
            state_in = S_PROBE2;
         end
         S_PROBE2: begin
            // First word arrives while the second is read.
            eq1_in   = flags.eq;
            lt1_in   = flags.lt;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_SPAN;
            priority if (eq1_ff) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{found: 1'b1, position: p1_ff};
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else if (flags.eq) begin
               rsp_valid_in = 1'b1;
               rsp_item_in  = '{found: 1'b1, position: p2_ff};
               busy_in      = 1'b0;
               state_in     = S_IDLE;
            end else if (lt1_ff) begin
               hi_in = {2'b00, p1_ff} - 12'd1;
            end else if (flags.gt) begin
               lo_in = {2'b00, p2_ff} + 12'd1;
            end else begin
               lo_in = {2'b00, p1_ff} + 12'd1;
               hi_in = {2'b00, p2_ff} - 12'd1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, registered outputs and search registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
      key_ff      <= key_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      span_ff     <= span_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      eq1_ff      <= eq1_in;
      lt1_ff      <= lt1_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // A result only appears once the search has released the block.
   `TSST_ASSERT(a_rsp_not_busy, clock, reset, rsp_valid |-> !busy, "result shown while busy")
   // An accepted search always occupies the block in the next cycle.
   `TSST_ASSERT(a_search_busy, clock, reset, (start && !busy && req_item.req_type == REQ_SEARCH) |=> busy, "search accepted without busy")
   // A miss always reports position zero.
   `TSST_ASSERT(a_miss_pos, clock, reset, (rsp_valid && !rsp_item.found) |-> (rsp_item.position == 10'd0), "miss with nonzero position")
   // Probe points stay ordered inside a round.
   `TSST_ASSERT(a_probe_order, clock, reset, (state_ff == S_DECIDE) |-> (p1_ff <= p2_ff), "probe points out of order")
   // No two results come in consecutive cycles.
   `TSST_NEVER(a_no_double_rsp, clock, reset, rsp_valid && $past(rsp_valid), "results in consecutive cycles")

endmodule

>>> hw/rtl/tsst_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
module tsst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when enabled; read data is always registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tsst_cmp.sv
// Shared signed comparator of the ternary search core.
// Depends on tsst_pkg for the flag struct.
module tsst_cmp
   import tsst_pkg::*;
(
   input  logic signed [31:0] key,
   input  logic signed [31:0] word,
   output cmp_flags_type      flags
);

   // Signed order between the key and the table word just read.
   always_comb begin
      flags.eq = (key == word);
      flags.lt = (key < word);
      flags.gt = (key > word);
   end

endmodule
